// File: rtl/core/uwet_pkg.sv
// ----------------------------------------------------------------------------
// uwet_pkg
// Shared types and codes for the undirected weighted edge table: operation
// and status codes, controller states and the controller/datapath interface.
// ----------------------------------------------------------------------------
package uwet_pkg;

  localparam int NODE_W  = 4;
  localparam int COST_W  = 15;
  localparam int FIELD_W = 16;
  localparam int ENTRY_W = NODE_W + COST_W;

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_ADD    = 2'd1,
    OP_REMOVE = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_NEG  = 2'd1,
    STAT_FULL = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ASEL_IDX,
    ASEL_IDX_NEXT,
    ASEL_TAIL
  } addr_sel_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_ADD_LA,
    ST_ADD_CHK,
    ST_ADD_WA,
    ST_ADD_WB,
    ST_SCAN_LOAD,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic      accept;
    logic      sel_b;
    logic      len_load;
    logic      idx_inc;
    logic      len_inc;
    logic      len_dec;
    logic      ram_re;
    logic      ram_we;
    logic      wr_shift;
    addr_sel_t addr_sel;
    logic      found_load;
    logic      status_load;
    status_t   status_code;
    logic      out_load;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       node_ok;
    logic       neg;
    logic       room;
    logic       idx_end;
    logic       shift_end;
    logic       match;
    logic       out_free;
  } stat_t;

endpackage

// File: rtl/core/uwet_ram.sv
// ----------------------------------------------------------------------------
// uwet_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module uwet_ram #(
  parameter int WIDTH = 19,
  parameter int DEPTH = 128
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                         wr_data,
  output logic [WIDTH-1:0]                         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wr_data;
    end
    if (re) begin
      rd_data <= mem[addr];
    end
  end

endmodule

// File: rtl/core/uwet_ctrl.sv
// ----------------------------------------------------------------------------
// uwet_ctrl
// Sequencer for lookup, add and remove: walks the lists one RAM access at a
// time and drives the datapath through a command struct.
// ----------------------------------------------------------------------------
module uwet_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  uwet_pkg::stat_t st,
  output uwet_pkg::cmd_t  cmd
);

  uwet_pkg::state_t state, state_next;
  logic             pass, pass_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= uwet_pkg::ST_IDLE;
      pass  <= 1'b0;
    end else begin
      state <= state_next;
      pass  <= pass_next;
    end
  end

  always_comb begin
    state_next      = state;
    pass_next       = pass;
    in_ready        = 1'b0;
    cmd             = '0;
    cmd.addr_sel    = uwet_pkg::ASEL_IDX;
    cmd.status_code = uwet_pkg::STAT_OK;
    cmd.sel_b       = pass;

    unique case (state)
      uwet_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = uwet_pkg::ST_DISPATCH;
        end
      end

      uwet_pkg::ST_DISPATCH: begin
        pass_next = 1'b0;
        cmd.sel_b = 1'b0;
        unique case (st.op)
          uwet_pkg::OP_LOOKUP,
          uwet_pkg::OP_REMOVE: begin
            state_next = st.node_ok ? uwet_pkg::ST_SCAN_LOAD : uwet_pkg::ST_DONE;
          end
          uwet_pkg::OP_ADD: begin
            priority if (st.neg) begin
              cmd.status_load = 1'b1;
              cmd.status_code = uwet_pkg::STAT_NEG;
              state_next      = uwet_pkg::ST_DONE;
            end else if (st.node_ok) begin
              state_next = uwet_pkg::ST_ADD_LA;
            end else begin
              state_next = uwet_pkg::ST_DONE;
            end
          end
          default: state_next = uwet_pkg::ST_DONE;
        endcase
      end

      uwet_pkg::ST_ADD_LA: begin
        cmd.sel_b    = 1'b0;
        cmd.len_load = 1'b1;
        state_next   = uwet_pkg::ST_ADD_CHK;
      end

      uwet_pkg::ST_ADD_CHK: begin
        cmd.sel_b = 1'b1;
        if (st.room) begin
          state_next = uwet_pkg::ST_ADD_WA;
        end else begin
          cmd.status_load = 1'b1;
          cmd.status_code = uwet_pkg::STAT_FULL;
          state_next      = uwet_pkg::ST_DONE;
        end
      end

      uwet_pkg::ST_ADD_WA: begin
        cmd.sel_b    = 1'b0;
        cmd.ram_we   = 1'b1;
        cmd.addr_sel = uwet_pkg::ASEL_TAIL;
        cmd.len_inc  = 1'b1;
        state_next   = uwet_pkg::ST_ADD_WB;
      end

      uwet_pkg::ST_ADD_WB: begin
        cmd.sel_b    = 1'b1;
        cmd.ram_we   = 1'b1;
        cmd.addr_sel = uwet_pkg::ASEL_TAIL;
        cmd.len_inc  = 1'b1;
        state_next   = uwet_pkg::ST_DONE;
      end

      uwet_pkg::ST_SCAN_LOAD: begin
        cmd.len_load = 1'b1;
        state_next   = uwet_pkg::ST_SCAN_RD;
      end

      uwet_pkg::ST_SCAN_RD: begin
        if (st.idx_end) begin
          if ((st.op == uwet_pkg::OP_REMOVE) && !pass) begin
            pass_next  = 1'b1;
            state_next = uwet_pkg::ST_SCAN_LOAD;
          end else begin
            state_next = uwet_pkg::ST_DONE;
          end
        end else begin
          cmd.ram_re = 1'b1;
          state_next = uwet_pkg::ST_SCAN_CHK;
        end
      end

      uwet_pkg::ST_SCAN_CHK: begin
        if (st.match) begin
          if (st.op == uwet_pkg::OP_LOOKUP) begin
            cmd.found_load = 1'b1;
            state_next     = uwet_pkg::ST_DONE;
          end else begin
            state_next = uwet_pkg::ST_SHIFT_RD;
          end
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = uwet_pkg::ST_SCAN_RD;
        end
      end

      uwet_pkg::ST_SHIFT_RD: begin
        if (st.shift_end) begin
          cmd.len_dec = 1'b1;
          if (!pass) begin
            pass_next  = 1'b1;
            state_next = uwet_pkg::ST_SCAN_LOAD;
          end else begin
            state_next = uwet_pkg::ST_DONE;
          end
        end else begin
          cmd.ram_re   = 1'b1;
          cmd.addr_sel = uwet_pkg::ASEL_IDX_NEXT;
          state_next   = uwet_pkg::ST_SHIFT_WR;
        end
      end

      uwet_pkg::ST_SHIFT_WR: begin
        cmd.ram_we   = 1'b1;
        cmd.wr_shift = 1'b1;
        cmd.idx_inc  = 1'b1;
        state_next   = uwet_pkg::ST_SHIFT_RD;
      end

      uwet_pkg::ST_DONE: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = uwet_pkg::ST_IDLE;
        end
      end

      default: state_next = uwet_pkg::ST_IDLE;
    endcase
  end

endmodule

// File: rtl/core/uwet_datapath.sv
// ----------------------------------------------------------------------------
// uwet_datapath
// Operand registers, list lengths, entry RAM, scan index and output register.
// ----------------------------------------------------------------------------
module uwet_datapath #(
  parameter int NODE_COUNT = 16,
  parameter int MAX_DEGREE = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  uwet_pkg::cmd_t      cmd,
  output uwet_pkg::stat_t     st,
  input  logic [1:0]          op,
  input  logic [3:0]          node_a,
  input  logic [3:0]          node_b,
  input  logic signed [15:0]  edge_cost,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [15:0]  found_cost,
  output logic [1:0]          status
);

  localparam int NODE_SPAN  = 2 ** uwet_pkg::NODE_W;
  localparam int LIST_COUNT = (NODE_COUNT < NODE_SPAN) ? NODE_COUNT : NODE_SPAN;
  localparam int LIW        = (LIST_COUNT > 1) ? $clog2(LIST_COUNT) : 1;
  localparam int LW         = $clog2(MAX_DEGREE + 1);
  localparam int DEPTH      = LIST_COUNT * MAX_DEGREE;
  localparam int AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [1:0]                      op_q;
  logic [uwet_pkg::NODE_W-1:0]     a_q, b_q;
  logic [uwet_pkg::FIELD_W-1:0]    cost_q;
  logic [LW-1:0]                   len_arr [LIST_COUNT];
  logic [LW-1:0]                   len_cur;
  logic [LW-1:0]                   idx;
  logic [uwet_pkg::FIELD_W-1:0]    found;
  logic [1:0]                      stat;

  logic [uwet_pkg::NODE_W-1:0]     sel_node, other;
  logic [LIW-1:0]                  list_sel;
  logic [LW-1:0]                   len_rd, idx_next, entry_idx;
  logic [AW-1:0]                   addr;
  logic [uwet_pkg::ENTRY_W-1:0]    wr_data, rd_data;
  logic                            self_loop;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_q   <= op;
      a_q    <= node_a;
      b_q    <= node_b;
      cost_q <= edge_cost;
    end
  end

  assign sel_node = cmd.sel_b ? b_q : a_q;
  assign other    = cmd.sel_b ? a_q : b_q;
  assign list_sel = sel_node[LIW-1:0];
  assign len_rd   = len_arr[list_sel];
  assign idx_next = idx + 1'b1;

  always_comb begin
    unique case (cmd.addr_sel)
      uwet_pkg::ASEL_IDX_NEXT: entry_idx = idx_next;
      uwet_pkg::ASEL_TAIL:     entry_idx = len_rd;
      default:                 entry_idx = idx;
    endcase
  end

  assign addr    = AW'(list_sel) * AW'(MAX_DEGREE) + AW'(entry_idx);
  assign wr_data = cmd.wr_shift ? rd_data : {other, cost_q[uwet_pkg::COST_W-1:0]};

  uwet_ram #(
    .WIDTH (uwet_pkg::ENTRY_W),
    .DEPTH (DEPTH)
  ) u_entry_ram (
    .clk     (clk),
    .we      (cmd.ram_we),
    .re      (cmd.ram_re),
    .addr    (addr),
    .wr_data (wr_data),
    .rd_data (rd_data)
  );

  // list lengths: reset empties every list at once
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LIST_COUNT; i++) begin
        len_arr[i] <= '0;
      end
    end else if (cmd.len_inc) begin
      len_arr[list_sel] <= len_rd + 1'b1;
    end else if (cmd.len_dec) begin
      len_arr[list_sel] <= len_cur - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.len_load) begin
      len_cur <= len_rd;
      idx     <= '0;
    end else if (cmd.idx_inc) begin
      idx <= idx_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      found <= '1;
      stat  <= uwet_pkg::STAT_OK;
    end else begin
      if (cmd.found_load) begin
        found <= {1'b0, rd_data[uwet_pkg::COST_W-1:0]};
      end
      if (cmd.status_load) begin
        stat <= cmd.status_code;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      found_cost <= found;
      status     <= stat;
    end
  end

  assign self_loop = (a_q == b_q);

  always_comb begin
    st.op        = op_q;
    st.node_ok   = (int'(a_q) < NODE_COUNT) && (int'(b_q) < NODE_COUNT);
    st.neg       = cost_q[uwet_pkg::FIELD_W-1];
    st.room      = self_loop
                 ? (({1'b0, len_cur} + (LW+1)'(2)) <= (LW+1)'(MAX_DEGREE))
                 : ((int'(len_cur) < MAX_DEGREE) && (int'(len_rd) < MAX_DEGREE));
    st.idx_end   = (idx == len_cur);
    st.shift_end = (idx_next == len_cur);
    st.match     = (rd_data[uwet_pkg::ENTRY_W-1 -: uwet_pkg::NODE_W] == other);
    st.out_free  = !out_valid || out_ready;
  end

endmodule

// File: rtl/core/undirected_weighted_edge_table_top.sv
// ----------------------------------------------------------------------------
// undirected_weighted_edge_table_top
// Undirected weighted graph held as ordered per-node adjacency lists.
// ----------------------------------------------------------------------------
// The block stores up to MAX_DEGREE (neighbour, cost) entries per node in one
// single-port entry RAM and answers one transaction at a time: lookup returns
// the cost of the first entry in node_a's list that names node_b (or -1), add
// appends the edge to both lists, remove deletes the first match from each
// list and slides the later entries down to keep their order. Every access
// to the entry RAM takes its own state and read data arrives in the cycle
// after the address, so each list entry visited takes a read state and then
// a check or write state. A new transaction is accepted whenever the
// sequencer is idle, even while the previous result still waits in the output
// register. Lists are empty right after reset; no clearing pass is needed.
// Node indexes not below NODE_COUNT make add and remove do nothing and make
// lookup answer -1.
// ----------------------------------------------------------------------------
module undirected_weighted_edge_table_top #(
  parameter int NODE_COUNT = 16,
  parameter int MAX_DEGREE = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         op,
  input  logic [3:0]         node_a,
  input  logic [3:0]         node_b,
  input  logic signed [15:0] edge_cost,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] found_cost,
  output logic [1:0]         status
);

  // commands down to the datapath, status back up to the sequencer
  uwet_pkg::cmd_t  cmd;
  uwet_pkg::stat_t st;

  // sequencer: decode the op, walk lists, hold until the result slot is free
  uwet_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  // storage and compare logic, plus the output register that parts the
  // result side from the input side
  uwet_datapath #(
    .NODE_COUNT (NODE_COUNT),
    .MAX_DEGREE (MAX_DEGREE)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .st         (st),
    .op         (op),
    .node_a     (node_a),
    .node_b     (node_b),
    .edge_cost  (edge_cost),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .found_cost (found_cost),
    .status     (status)
  );

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - undirected weighted edge table testbench
// Drives lookup, add, remove and reserved-code transactions into the table.
// An internal adjacency-list copy predicts every answer, and a scoreboard
// compares each result in order. Both handshake sides idle at random, and
// the result side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb;

  localparam int NODES        = 16;
  localparam int DEGREE       = 8;
  localparam int RANDOM_ITEMS = 1600;
  localparam int QUIET_ITEMS  = 200;      // tail of the run without idling
  localparam int DRAIN_CYCLES = 60;
  localparam int CYCLE_LIMIT  = 400_000;
  localparam int HOLD_AFTER   = 400;      // transactions before the long hold
  localparam int HOLD_CYCLES  = 250;
  localparam int REPORT_MAX   = 10;

  localparam logic [1:0]         OP_RESERVED = 2'd3;
  localparam logic signed [15:0] NO_EDGE     = -16'sd1;
  localparam logic signed [15:0] COST_MAX    = 16'sh7FFF;
  localparam logic signed [15:0] COST_MIN    = 16'sh8000;

  typedef struct {
    logic signed [15:0]  cost;
    uwet_pkg::status_t   status;
  } edge_answer_t;

  // --------------------------------------------------------------------------
  // Scoreboard: keeps its own copy of the adjacency lists and the queue of
  // answers still owed by the block.
  // --------------------------------------------------------------------------
  class edge_table_scoreboard;
    logic [3:0]   nbr_mem  [NODES][DEGREE];
    logic [14:0]  cost_mem [NODES][DEGREE];
    int           list_len [NODES];
    edge_answer_t answers_due[$];
    int unsigned  mismatches;
    int unsigned  requests_noted;
    int unsigned  results_checked;
    int unsigned  op_seen [4];
    int unsigned  lookup_hits;
    int unsigned  neg_rejects;
    int unsigned  full_rejects;

    function new();
      foreach (list_len[n]) list_len[n] = 0;
      foreach (op_seen[k]) op_seen[k] = 0;
      mismatches      = 0;
      requests_noted  = 0;
      results_checked = 0;
      lookup_hits     = 0;
      neg_rejects     = 0;
      full_rejects    = 0;
    endfunction

    function void log_failure(string what);
      mismatches++;
      if (mismatches <= REPORT_MAX) $display("[%0t] MISMATCH: %s", $realtime, what);
    endfunction

    function void append_entry(int node, logic [3:0] peer, logic [14:0] cost);
      nbr_mem[node][list_len[node]]  = peer;
      cost_mem[node][list_len[node]] = cost;
      list_len[node]++;
    endfunction

    // Drop the first entry naming peer and slide the later ones down.
    function void drop_first(int node, logic [3:0] peer);
      int hit;
      hit = -1;
      for (int i = list_len[node] - 1; i >= 0; i--)
        if (nbr_mem[node][i] == peer) hit = i;
      if (hit >= 0) begin
        for (int j = hit; j + 1 < list_len[node]; j++) begin
          nbr_mem[node][j]  = nbr_mem[node][j + 1];
          cost_mem[node][j] = cost_mem[node][j + 1];
        end
        list_len[node]--;
      end
    endfunction

    function void note_request(logic [1:0] code, logic [3:0] a, logic [3:0] b,
                               logic signed [15:0] cost);
      edge_answer_t want;
      bit           room;
      want.cost   = NO_EDGE;
      want.status = uwet_pkg::STAT_OK;
      requests_noted++;
      op_seen[code]++;
      case (code)
        uwet_pkg::OP_LOOKUP: begin
          // walk backwards so the first match wins
          for (int i = list_len[a] - 1; i >= 0; i--)
            if (nbr_mem[a][i] == b) want.cost = {1'b0, cost_mem[a][i]};
          if (want.cost != NO_EDGE) lookup_hits++;
        end
        uwet_pkg::OP_ADD: begin
          if (cost < 0) begin
            want.status = uwet_pkg::STAT_NEG;
            neg_rejects++;
          end else begin
            if (a == b) room = (list_len[a] + 2 <= DEGREE);
            else        room = (list_len[a] < DEGREE) && (list_len[b] < DEGREE);
            if (room) begin
              append_entry(a, b, cost[14:0]);
              append_entry(b, a, cost[14:0]);
            end else begin
              want.status = uwet_pkg::STAT_FULL;
              full_rejects++;
            end
          end
        end
        uwet_pkg::OP_REMOVE: begin
          drop_first(a, b);
          drop_first(b, a);
        end
        default: ;
      endcase
      answers_due.insert(answers_due.size(), want);
    endfunction

    function void check_result(logic signed [15:0] got_cost, logic [1:0] got_status);
      edge_answer_t want;
      if (answers_due.size() == 0) begin
        log_failure($sformatf("result with nothing pending: cost=%0d status=%0d",
                              got_cost, got_status));
        return;
      end
      want = answers_due.pop_front();
      results_checked++;
      if (got_cost !== want.cost || got_status !== want.status)
        log_failure($sformatf("result %0d: expected cost=%0d status=%0d, got cost=%0d status=%0d",
                              results_checked, want.cost, want.status, got_cost, got_status));
    endfunction

    function void flag_leftovers();
      if (answers_due.size() != 0)
        log_failure($sformatf("%0d expected results never arrived", answers_due.size()));
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Signals and the block
  // --------------------------------------------------------------------------
  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic [1:0]         op;
  logic [3:0]         node_a;
  logic [3:0]         node_b;
  logic signed [15:0] edge_cost;
  logic               out_valid;
  logic               out_ready;
  logic signed [15:0] found_cost;
  logic [1:0]         status;

  edge_table_scoreboard table_sb;
  bit                   quiet_tail;
  int unsigned          cycle_count;

  undirected_weighted_edge_table_top #(
    .NODE_COUNT(NODES),
    .MAX_DEGREE(DEGREE)
  ) DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .op        (op),
    .node_a    (node_a),
    .node_b    (node_b),
    .edge_cost (edge_cost),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .found_cost(found_cost),
    .status    (status)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Sender: optionally idle for a random burst, then offer one transaction
  // and hold it until the block takes it. Note it in the scoreboard at the
  // accepting edge.
  // --------------------------------------------------------------------------
  task automatic send_request(input logic [1:0] code, input logic [3:0] a,
                              input logic [3:0] b, input logic signed [15:0] cost);
    int gap;
    if (!quiet_tail && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 12);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    op        <= code;
    node_a    <= a;
    node_b    <= b;
    edge_cost <= cost;
    // sample right after the edge: registered values are still pre-edge
    do @(posedge clk); while (in_ready !== 1'b1);
    table_sb.note_request(code, a, b, cost);
  endtask

  // --------------------------------------------------------------------------
  // Receiver: check every accepted result, then decide out_ready for the
  // next edge. Stall in random bursts, and once hold off for a long stretch
  // so the output register fills and the block stops taking transactions.
  // --------------------------------------------------------------------------
  initial begin
    int  stall_left;
    bit  long_hold_done;
    stall_left     = 0;
    long_hold_done = 0;
    out_ready      = 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid === 1'b1 && out_ready === 1'b1)
        table_sb.check_result(found_cost, status);
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (!long_hold_done && table_sb.requests_noted >= HOLD_AFTER) begin
        long_hold_done = 1;
        stall_left     = HOLD_CYCLES - 1;
        out_ready     <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 12) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Stop a hung run.
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[%0t] run exceeded %0d cycles", $realtime, CYCLE_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    int unsigned        hot_base;
    int unsigned        pick;
    logic [1:0]         code;
    logic [3:0]         a;
    logic [3:0]         b;
    logic signed [15:0] cost;

    table_sb   = new();
    quiet_tail = 0;
    rst        = 1'b1;
    in_valid   = 1'b0;
    op         = uwet_pkg::OP_LOOKUP;
    node_a     = '0;
    node_b     = '0;
    edge_cost  = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: empty table, extreme costs, negative rejects, self loop,
    // missing remove, reserved code, full lists and order kept on removal.
    send_request(uwet_pkg::OP_LOOKUP, 4'd0,  4'd1,  16'sd0);    // empty list
    send_request(uwet_pkg::OP_ADD,    4'd0,  4'd1,  COST_MAX);
    send_request(uwet_pkg::OP_ADD,    4'd0,  4'd1,  16'sd0);    // duplicate edge
    send_request(uwet_pkg::OP_LOOKUP, 4'd1,  4'd0,  16'sd0);    // first match wins
    send_request(uwet_pkg::OP_ADD,    4'd2,  4'd3,  COST_MIN);  // rejected
    send_request(uwet_pkg::OP_ADD,    4'd2,  4'd3,  NO_EDGE);   // rejected
    send_request(uwet_pkg::OP_ADD,    4'd15, 4'd15, 16'sd5);    // self loop
    send_request(uwet_pkg::OP_LOOKUP, 4'd15, 4'd15, COST_MIN);
    send_request(uwet_pkg::OP_REMOVE, 4'd15, 4'd15, COST_MAX);  // drops both entries
    send_request(uwet_pkg::OP_LOOKUP, 4'd15, 4'd15, 16'sd0);
    send_request(uwet_pkg::OP_REMOVE, 4'd4,  4'd5,  16'sd0);    // missing edge
    send_request(OP_RESERVED,         4'd15, 4'd0,  NO_EDGE);
    for (int k = 2; k <= 6; k++)
      send_request(uwet_pkg::OP_ADD, 4'd0, 4'(k), 16'(100 * k)); // node 0 at seven
    send_request(uwet_pkg::OP_ADD,    4'd0,  4'd0,  16'sd7);    // self loop, no room
    send_request(uwet_pkg::OP_ADD,    4'd0,  4'd7,  16'sd700);  // node 0 now full
    send_request(uwet_pkg::OP_ADD,    4'd0,  4'd8,  16'sd1);    // full on node_a
    send_request(uwet_pkg::OP_ADD,    4'd9,  4'd0,  16'sd1);    // full on node_b
    send_request(uwet_pkg::OP_ADD,    4'd0,  4'd9,  -16'sd3);   // sign beats full
    send_request(uwet_pkg::OP_REMOVE, 4'd0,  4'd1,  16'sd0);    // first of two
    send_request(uwet_pkg::OP_LOOKUP, 4'd0,  4'd1,  16'sd0);
    send_request(uwet_pkg::OP_LOOKUP, 4'd0,  4'd7,  16'sd0);

    // Random part: mostly a hot window of four nodes so lists fill, match
    // and drain; lookups and removes often aim at an edge that exists.
    hot_base = $urandom_range(0, NODES - 4);
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      quiet_tail = (i >= RANDOM_ITEMS - QUIET_ITEMS);
      if (i % 128 == 0) hot_base = $urandom_range(0, NODES - 4);
      if ($urandom_range(0, 9) < 7) begin
        a = 4'(hot_base + $urandom_range(0, 3));
        b = 4'(hot_base + $urandom_range(0, 3));
      end else begin
        a = 4'($urandom_range(0, NODES - 1));
        b = 4'($urandom_range(0, NODES - 1));
      end
      cost = 16'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 35)      code = uwet_pkg::OP_LOOKUP;
      else if (pick < 65) code = uwet_pkg::OP_ADD;
      else if (pick < 95) code = uwet_pkg::OP_REMOVE;
      else                code = OP_RESERVED;
      if (code == uwet_pkg::OP_ADD) begin
        pick = $urandom_range(0, 99);
        if (pick < 12)      cost = {1'b1, 15'($urandom)};
        else if (pick < 18) cost = 16'sd0;
        else if (pick < 24) cost = COST_MAX;
        else                cost = {1'b0, 15'($urandom)};
      end else if ((code == uwet_pkg::OP_LOOKUP || code == uwet_pkg::OP_REMOVE) &&
                   table_sb.list_len[a] > 0 && $urandom_range(0, 9) < 6) begin
        b = table_sb.nbr_mem[a][$urandom_range(0, table_sb.list_len[a] - 1)];
      end
      send_request(code, a, b, cost);
    end
    in_valid <= 1'b0;

    // Drain: wait for every answer, then give the block time for strays.
    while (table_sb.answers_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    table_sb.flag_leftovers();

    $display("Ran %0d transactions: %0d lookups (%0d hits), %0d adds, %0d removes, %0d reserved",
             table_sb.requests_noted, table_sb.op_seen[uwet_pkg::OP_LOOKUP],
             table_sb.lookup_hits, table_sb.op_seen[uwet_pkg::OP_ADD],
             table_sb.op_seen[uwet_pkg::OP_REMOVE], table_sb.op_seen[OP_RESERVED]);
    $display("Adds rejected: %0d negative, %0d full; %0d results checked, %0d mismatches",
             table_sb.neg_rejects, table_sb.full_rejects, table_sb.results_checked,
             table_sb.mismatches);
    if (table_sb.mismatches == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
